@@ hdl/tksd_pkg.sv @@
// shared types, constants and decode functions for the terminal key sequence decoder
`default_nettype none

package tksd_pkg;

    // default sizing
    localparam int unsigned MAX_SEQ_LEN_DEF = 32;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // fixed field widths
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned PARAM_W = 20;
    localparam int unsigned ACC_W   = 24;

    localparam logic [PARAM_W-1:0] PARAM_CAP = 20'd1000000;

    // byte values
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_ETX      = 8'h03;
    localparam logic [7:0] CH_SUB      = 8'h1A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SS3      = 8'h4F;
    localparam logic [7:0] CH_FOCUS_IN = 8'h49;
    localparam logic [7:0] CH_KITTY    = 8'h75;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UP       = 8'h41;
    localparam logic [7:0] CH_DOWN     = 8'h42;
    localparam logic [7:0] CH_RIGHT    = 8'h43;
    localparam logic [7:0] CH_LEFT     = 8'h44;
    localparam logic [7:0] FINAL_LO    = 8'h40;
    localparam logic [7:0] FINAL_HI    = 8'h7E;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CSI  = 2'd2,
        MODE_SS3  = 2'd3
    } t_seq_mode;

    typedef enum logic [3:0] {
        KEY_ENTER     = 4'd0,
        KEY_TAB       = 4'd1,
        KEY_BACKSPACE = 4'd2,
        KEY_INTERRUPT = 4'd3,
        KEY_SUSPEND   = 4'd4,
        KEY_SPACE     = 4'd5,
        KEY_CHARACTER = 4'd6,
        KEY_ESCAPE    = 4'd7,
        KEY_UP        = 4'd8,
        KEY_DOWN      = 4'd9,
        KEY_LEFT      = 4'd10,
        KEY_RIGHT     = 4'd11,
        KEY_FOCUS_IN  = 4'd12,
        KEY_FOCUS_OUT = 4'd13
    } t_key_code;

    typedef enum logic [1:0] {
        PHASE_PRESS   = 2'd0,
        PHASE_REPEAT  = 2'd1,
        PHASE_RELEASE = 2'd2
    } t_key_phase;

    typedef struct packed {
        t_key_code  key;
        logic [6:0] ch;
        t_key_phase phase;
    } t_key_evt;

    typedef struct packed {
        logic     hit;
        t_key_evt evt;
    } t_opt_evt;

    // key events caused by one request, one or two
    typedef struct packed {
        logic     two;
        t_key_evt first;
        t_key_evt second;
    } t_key_run;

    function automatic t_opt_evt mk_evt(t_key_code key, logic [6:0] ch, t_key_phase phase);
        t_opt_evt r;
        r.hit       = 1'b1;
        r.evt.key   = key;
        r.evt.ch    = ch;
        r.evt.phase = phase;
        return r;
    endfunction

    function automatic t_key_phase phase_of(logic [PARAM_W-1:0] ev);
        t_key_phase p;
        if (ev == PARAM_W'(2))      p = PHASE_REPEAT;
        else if (ev == PARAM_W'(3)) p = PHASE_RELEASE;
        else                        p = PHASE_PRESS;
        return p;
    endfunction

    // arrow final byte, shared by ss3 and csi
    function automatic t_opt_evt arrow_of(logic [7:0] b);
        t_opt_evt r;
        r = '0;
        if (b == CH_UP)         r = mk_evt(KEY_UP, 7'd0, PHASE_PRESS);
        else if (b == CH_DOWN)  r = mk_evt(KEY_DOWN, 7'd0, PHASE_PRESS);
        else if (b == CH_RIGHT) r = mk_evt(KEY_RIGHT, 7'd0, PHASE_PRESS);
        else if (b == CH_LEFT)  r = mk_evt(KEY_LEFT, 7'd0, PHASE_PRESS);
        return r;
    endfunction

    // byte outside any sequence
    function automatic t_opt_evt plain_decode(logic [7:0] b);
        t_opt_evt r;
        r = '0;
        if (b == CH_CR || b == CH_LF)       r = mk_evt(KEY_ENTER, 7'd0, PHASE_PRESS);
        else if (b == CH_TAB)               r = mk_evt(KEY_TAB, 7'd0, PHASE_PRESS);
        else if (b == CH_DEL || b == CH_BS) r = mk_evt(KEY_BACKSPACE, 7'd0, PHASE_PRESS);
        else if (b == CH_ETX)               r = mk_evt(KEY_INTERRUPT, 7'd0, PHASE_PRESS);
        else if (b == CH_SUB)               r = mk_evt(KEY_SUSPEND, 7'd0, PHASE_PRESS);
        else if (b == CH_SPACE)             r = mk_evt(KEY_SPACE, 7'd0, PHASE_PRESS);
        else if (b > CH_SPACE && b < CH_DEL) r = mk_evt(KEY_CHARACTER, b[6:0], PHASE_PRESS);
        return r;
    endfunction

    // kitty keyboard protocol key, code in the first parameter
    function automatic t_opt_evt kitty_decode(logic [PARAM_W-1:0] c,
                                              logic [PARAM_W-1:0] mods,
                                              logic [PARAM_W-1:0] ev);
        t_opt_evt           r;
        logic [PARAM_W-1:0] mod_m1;
        logic               ctrl;
        t_key_phase         ph;
        r      = '0;
        mod_m1 = mods - PARAM_W'(1);
        ctrl   = mod_m1[2];
        ph     = phase_of(ev);
        if (ctrl) begin
            if (c == PARAM_W'(8'h63) || c == PARAM_W'(8'h43)) begin
                r = mk_evt(KEY_INTERRUPT, 7'd0, ph);
            end else if (c == PARAM_W'(8'h7A) || c == PARAM_W'(8'h5A)) begin
                r = mk_evt(KEY_SUSPEND, 7'd0, ph);
            end
        end else if (c == PARAM_W'(CH_ESC)) begin
            r = mk_evt(KEY_ESCAPE, 7'd0, ph);
        end else if (c == PARAM_W'(CH_CR)) begin
            r = mk_evt(KEY_ENTER, 7'd0, ph);
        end else if (c == PARAM_W'(CH_TAB)) begin
            r = mk_evt(KEY_TAB, 7'd0, ph);
        end else if (c == PARAM_W'(CH_DEL) || c == PARAM_W'(CH_BS)) begin
            r = mk_evt(KEY_BACKSPACE, 7'd0, ph);
        end else if (c == PARAM_W'(CH_SPACE)) begin
            r = mk_evt(KEY_SPACE, 7'd0, ph);
        end else if (c > PARAM_W'(CH_SPACE) && c < PARAM_W'(CH_DEL)) begin
            r = mk_evt(KEY_CHARACTER, c[6:0], ph);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tksd_front.sv @@
// front end: accepts bytes, runs the escape sequence parser and forms key runs
`default_nettype none

module tksd_front
    import tksd_pkg::*;
#(
    parameter int unsigned MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_command,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_queue_full,
    output logic            o_push,
    output t_key_run        o_run
);

    t_seq_mode          r_mode, n_mode;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [PARAM_W-1:0] r_first, n_first;
    logic [PARAM_W-1:0] r_mod, n_mod;
    logic [PARAM_W-1:0] r_event, n_event;
    logic [PARAM_W-1:0] r_digit, n_digit;
    logic               r_dseen, n_dseen;
    logic [1:0]         r_field, n_field;
    logic [1:0]         r_sub, n_sub;
    logic               r_fiq, n_fiq;

    logic               w_accept;
    logic [PARAM_W-1:0] w_first_c, w_mod_c, w_event_c;
    logic [ACC_W-1:0]   w_acc;
    logic [PARAM_W-1:0] w_sat;
    logic               w_is_final;
    logic               w_is_digit;
    t_opt_evt           w_arrow;
    t_opt_evt           w_csi;
    t_opt_evt           w_seq_evt;
    t_opt_evt           w_fresh_evt;
    logic               w_fresh;
    logic               w_clear;

    assign o_in_ready = !i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;

    // parameter values as they stand once the pending digits are committed
    assign w_first_c = (r_dseen && r_field == 2'd0 && r_sub == 2'd0) ? r_digit : r_first;
    assign w_mod_c   = (r_dseen && r_field == 2'd1 && r_sub == 2'd0) ? r_digit : r_mod;
    assign w_event_c = (r_dseen && r_field == 2'd1 && r_sub == 2'd1) ? r_digit : r_event;

    // decimal accumulator with saturation
    assign w_is_digit = i_data_byte >= CH_ZERO && i_data_byte <= CH_NINE;
    assign w_acc = ACC_W'(r_dseen ? r_digit : '0) * ACC_W'(10) + ACC_W'(i_data_byte[3:0]);
    assign w_sat = (w_acc > ACC_W'(PARAM_CAP)) ? PARAM_CAP : w_acc[PARAM_W-1:0];

    // csi final byte decode
    assign w_is_final = i_data_byte >= FINAL_LO && i_data_byte <= FINAL_HI;
    assign w_arrow    = arrow_of(i_data_byte);

    always_comb begin
        w_csi = '0;
        if (w_arrow.hit) begin
            w_csi           = w_arrow;
            w_csi.evt.phase = phase_of(w_event_c);
        end else if (i_data_byte == CH_KITTY && !r_fiq) begin
            w_csi = kitty_decode(w_first_c, w_mod_c, w_event_c);
        end else if (i_data_byte == CH_FOCUS_IN && r_len == LEN_W'(2)) begin
            w_csi = mk_evt(KEY_FOCUS_IN, 7'd0, PHASE_PRESS);
        end else if (i_data_byte == CH_SS3 && r_len == LEN_W'(2)) begin
            w_csi = mk_evt(KEY_FOCUS_OUT, 7'd0, PHASE_PRESS);
        end
    end

    // parser next state and the events of this request
    always_comb begin
        n_mode      = r_mode;
        n_len       = r_len;
        n_first     = r_first;
        n_mod       = r_mod;
        n_event     = r_event;
        n_digit     = r_digit;
        n_dseen     = r_dseen;
        n_field     = r_field;
        n_sub       = r_sub;
        n_fiq       = r_fiq;
        w_seq_evt   = '0;
        w_fresh_evt = '0;
        w_fresh     = 1'b0;
        w_clear     = 1'b0;
        if (w_accept) begin
            if (i_command) begin
                if (r_mode == MODE_ESC) w_seq_evt = mk_evt(KEY_ESCAPE, 7'd0, PHASE_PRESS);
                w_clear = 1'b1;
            end else begin
                unique case (r_mode)
                    MODE_ESC: begin
                        if (i_data_byte == CH_LBRACKET) begin
                            n_mode = MODE_CSI;
                            n_len  = LEN_W'(2);
                        end else if (i_data_byte == CH_SS3) begin
                            n_mode = MODE_SS3;
                            n_len  = LEN_W'(2);
                        end else begin
                            w_seq_evt = mk_evt(KEY_ESCAPE, 7'd0, PHASE_PRESS);
                            w_clear   = 1'b1;
                            w_fresh   = 1'b1;
                        end
                    end
                    MODE_CSI: begin
                        if (w_is_final) begin
                            w_seq_evt = w_csi;
                            w_clear   = 1'b1;
                        end else if (r_len < LEN_W'(MAX_SEQ_LEN)) begin
                            // parameter or intermediate byte
                            if (r_len == LEN_W'(2)) n_fiq = (i_data_byte == CH_QUESTION);
                            if (w_is_digit) begin
                                n_digit = w_sat;
                                n_dseen = 1'b1;
                            end else if (i_data_byte == CH_COLON) begin
                                n_first = w_first_c;
                                n_mod   = w_mod_c;
                                n_event = w_event_c;
                                n_digit = '0;
                                n_dseen = 1'b0;
                                if (r_sub < 2'd2) n_sub = r_sub + 2'd1;
                            end else if (i_data_byte == CH_SEMI) begin
                                n_first = w_first_c;
                                n_mod   = w_mod_c;
                                n_event = w_event_c;
                                n_digit = '0;
                                n_dseen = 1'b0;
                                if (r_field < 2'd2) n_field = r_field + 2'd1;
                                n_sub = 2'd0;
                            end
                            n_len = r_len + LEN_W'(1);
                        end else begin
                            // too long: drop and decode this byte again
                            w_clear = 1'b1;
                            w_fresh = 1'b1;
                        end
                    end
                    MODE_SS3: begin
                        w_seq_evt = w_arrow;
                        w_clear   = 1'b1;
                    end
                    MODE_IDLE: begin
                        w_fresh = 1'b1;
                    end
                endcase
            end
            if (w_clear) begin
                n_mode  = MODE_IDLE;
                n_len   = '0;
                n_first = PARAM_W'(1);
                n_mod   = PARAM_W'(1);
                n_event = PARAM_W'(1);
                n_digit = '0;
                n_dseen = 1'b0;
                n_field = 2'd0;
                n_sub   = 2'd0;
                n_fiq   = 1'b0;
            end
            // byte seen as if no sequence were pending
            if (w_fresh) begin
                if (i_data_byte == CH_ESC) begin
                    n_mode = MODE_ESC;
                    n_len  = LEN_W'(1);
                end else begin
                    w_fresh_evt = plain_decode(i_data_byte);
                end
            end
        end
    end

    // hand the run to the queue
    assign o_push       = w_accept && (w_seq_evt.hit || w_fresh_evt.hit);
    assign o_run.two    = w_seq_evt.hit && w_fresh_evt.hit;
    assign o_run.first  = w_seq_evt.hit ? w_seq_evt.evt : w_fresh_evt.evt;
    assign o_run.second = w_fresh_evt.evt;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_len   <= '0;
            r_first <= PARAM_W'(1);
            r_mod   <= PARAM_W'(1);
            r_event <= PARAM_W'(1);
            r_digit <= '0;
            r_dseen <= 1'b0;
            r_field <= 2'd0;
            r_sub   <= 2'd0;
            r_fiq   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_first <= n_first;
            r_mod   <= n_mod;
            r_event <= n_event;
            r_digit <= n_digit;
            r_dseen <= n_dseen;
            r_field <= n_field;
            r_sub   <= n_sub;
            r_fiq   <= n_fiq;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tksd_queue.sv @@
// small run queue between the parser and the output sequencer
`default_nettype none

module tksd_queue
    import tksd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_key_run i_run,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_key_run      o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_key_run         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop)      n_count = r_count + CNT_W'(1);
        else if (w_pop && !w_push) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_run;
    end

endmodule

`default_nettype wire

@@ hdl/tksd_back.sv @@
// back end: splits each run into key events and drives the output register
`default_nettype none

module tksd_back
    import tksd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_empty,
    input  wire t_key_run i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_key_evt      o_evt,
    output logic          o_last
);

    logic     r_out_valid, n_out_valid;
    logic     r_half, n_half;
    t_key_evt r_evt, n_evt;
    logic     r_last, n_last;
    logic     w_load;

    assign w_load = !r_out_valid || i_out_ready;

    // pick the next event: first half of a pair, or the last of a run
    always_comb begin
        n_out_valid = r_out_valid;
        n_half      = r_half;
        n_evt       = r_evt;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (w_load) begin
            n_out_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.two && !r_half) begin
                    n_evt  = i_head.first;
                    n_last = 1'b0;
                    n_half = 1'b1;
                end else begin
                    n_evt  = r_half ? i_head.second : i_head.first;
                    n_last = 1'b1;
                    n_half = 1'b0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_half      <= n_half;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_evt  <= n_evt;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_evt       = r_evt;
    assign o_last      = r_last;

endmodule

`default_nettype wire

@@ hdl/terminal_key_sequence_decoder.sv @@
// top level of the terminal key sequence decoder
`default_nettype none

// Decodes terminal input bytes (plain keys, ESC, SS3 arrows, CSI arrows, kitty keys and
// focus reports) into key events. One request is taken per clock while the queue is not
// full, and an ESC followed by an unrelated byte can yield two events that leave one after
// the other. The parser updates its registers in the cycle a byte is taken, and a queue of
// QUEUE_DEPTH runs lets the parser keep taking bytes while the output side is stalled. The
// first event of a request passes through the queue and then the output register. A
// command of 1 flushes a pending sequence.

module terminal_key_sequence_decoder
    import tksd_pkg::*;
#(
    parameter int unsigned MAX_SEQ_LEN = MAX_SEQ_LEN_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_command,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [3:0]      o_key_code,
    output logic [6:0]      o_char_code,
    output logic [1:0]      o_key_phase,
    output logic            o_last_of_run
);

    logic     w_push, w_full, w_pop, w_empty;
    t_key_run w_run, w_head;
    t_key_evt w_evt;

    tksd_front #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_run        (w_run)
    );

    tksd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_run),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    tksd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_evt       (w_evt),
        .o_last      (o_last_of_run)
    );

    // result fields
    assign o_key_code  = w_evt.key;
    assign o_char_code = w_evt.ch;
    assign o_key_phase = w_evt.phase;

endmodule

`default_nettype wire

@@ hdl/tksd_checker.sv @@
// port level checks for the terminal key sequence decoder, bound to the top level
`default_nettype none

module tksd_checker
    import tksd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] o_key_code,
    input wire logic [6:0] o_char_code,
    input wire logic [1:0] o_key_phase,
    input wire logic       o_last_of_run
);

    // a stalled event holds with its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_code)
            && $stable(o_char_code) && $stable(o_key_phase) && $stable(o_last_of_run))
        else $error("stalled key event changed");

    // key code within the defined set
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_key_code <= KEY_FOCUS_OUT)
        else $error("undefined key code");

    // character field is set exactly for character keys
    a_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_char_code != 7'd0) == (o_key_code == KEY_CHARACTER)))
        else $error("char code does not match key code");

    // focus reports always press, and the unused phase code never appears
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_key_code == KEY_FOCUS_IN || o_key_code == KEY_FOCUS_OUT
            || o_key_phase == 2'd3) |-> o_key_phase == PHASE_PRESS)
        else $error("bad key phase");

    // the first of a pair is always an escape
    a_pair_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_key_code == KEY_ESCAPE)
        else $error("unexpected first event of a pair");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_key_code    (o_key_code),
    .o_char_code   (o_char_code),
    .o_key_phase   (o_key_phase),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire
